### design/rps_pkg.sv
`timescale 1ns / 1ps

package rps_pkg;

    localparam int TEMP_WIDTH = 9;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOAK        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY = 3'd4;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RAMP   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SOAK   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HEAT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_REFLOW = 3'd4;

    localparam int PROG_W = 13;

    // signed numerator width and its magnitude width for the shared divider
    localparam int NUM_W     = 20;
    localparam int QUO_W     = NUM_W - 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int DCNT_W    = 5;

    // divide by 25 as multiply by 5243 and shift by 17, exact below 2^13
    localparam int          NUM1_W      = 13;
    localparam logic [12:0] RECIP25     = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

endpackage

### design/rps_if.sv
`timescale 1ns / 1ps

interface rps_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [rps_pkg::TEMP_WIDTH-1:0]  measured_temp;
    logic                            heater_on;
    logic                            temp_reached;
    logic                            display_asleep;
    logic [7:0]                      start_target;

    modport source (
        output valid, op, measured_temp, heater_on, temp_reached, display_asleep,
               start_target,
        input  ready
    );
    modport sink (
        input  valid, op, measured_temp, heater_on, temp_reached, display_asleep,
               start_target,
        output ready
    );
endinterface

interface rps_out_if;
    logic                              valid;
    logic                              ready;
    logic [rps_pkg::PHASE_W-1:0]       phase;
    logic [7:0]                        target_temp;
    logic signed [rps_pkg::PROG_W-1:0] progress;
    logic                              sleep_request;
    logic                              profile_done;

    modport source (
        output valid, phase, target_temp, progress, sleep_request, profile_done,
        input  ready
    );
    modport sink (
        input  valid, phase, target_temp, progress, sleep_request, profile_done,
        output ready
    );
endinterface

### design/reflow_profile_sequencer.sv
`timescale 1ns / 1ps

// Reflow profile sequencer, one transfer per second of process time.
// item:   input channel (valid/ready). op selects a one-second tick or a
//         profile start; a tick carries plate temperature and status flags.
// result: output channel, exactly one transfer per item: phase, target,
//         signed progress percent, sleep request and profile-done pulses.
// cfg_*:  write port for the five profile registers; the user writes them
//         only while idle, and the block itself does not enforce it.
// A start item or a tick in the idle phase goes straight to the finish
// state; a tick in phases 1 to 4 passes the reciprocal load, the divider
// load and the divider. The phase divisor comes from a reciprocal multiply
// by 1/25; the progress quotient from one restoring divider, one quotient
// bit per cycle, 19 bits. item.ready is high only while no item is in work.
// The result sits in an output register; the next item is taken while it
// waits, and its own result is held back until the receiver takes the
// previous one.
// Reset: profile registers return to their defaults, phase goes to idle,
// counters, target and progress clear, no result is pending.

module reflow_profile_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rps_pkg::CFG_DATA_W-1:0]   cfg_data,
    rps_in_if.sink                           item,
    rps_out_if.source                        result
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD1 = 5'b00010,
        S_LOAD2 = 5'b00100,
        S_DIV2  = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    localparam int NW = rps_pkg::NUM_W;
    localparam int QW = rps_pkg::QUO_W;
    localparam int TW = rps_pkg::TEMP_WIDTH;
    localparam int PW = rps_pkg::PROG_W;
    localparam int RW = rps_pkg::NUM1_W;

    function automatic logic signed [NW-1:0] mul10(input logic signed [NW-1:0] x);
        return (x <<< 3) + (x <<< 1);
    endfunction

    // profile registers
    logic [7:0] preheat_reg;
    logic [8:0] soak_reg;
    logic [7:0] peak_reg;
    logic [8:0] reflow_reg;
    logic [7:0] sleep_delay_reg;

    state_t                       state_reg, state_next;
    logic [rps_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [15:0]                  second_count_reg, second_count_next;
    logic [7:0]                   ramp_reg, ramp_next;
    logic signed [PW-1:0]         progress_reg, progress_next;
    logic [7:0]                   idle_count_reg, idle_count_next;
    logic [TW-1:0]                now_reg, now_next;
    logic                         sleep_pend_reg, sleep_pend_next;
    logic                         active_reg, active_next;

    logic [7:0]                   div_rem_reg, div_rem_next;
    logic [QW-1:0]                div_quo_reg, div_quo_next;
    logic [7:0]                   div_den_reg, div_den_next;
    logic                         div_neg_reg, div_neg_next;
    logic [rps_pkg::DCNT_W-1:0]   div_cnt_reg, div_cnt_next;

    logic                         out_valid_reg, out_valid_next;
    logic [rps_pkg::PHASE_W-1:0]  out_phase_reg, out_phase_next;
    logic [7:0]                   out_target_reg, out_target_next;
    logic signed [PW-1:0]         out_progress_reg, out_progress_next;
    logic                         out_sleep_reg, out_sleep_next;
    logic                         out_done_reg, out_done_next;

    logic                         accept;
    logic                         out_free;
    logic [8:0]                   div_shift;
    logic [8:0]                   div_diff;
    logic                         div_ge;
    logic                         div_last;
    logic signed [NW-1:0]         quo_signed;
    logic signed [NW-1:0]         num1;
    logic signed [NW-1:0]         num2;
    logic signed [NW-1:0]         num_sel;
    logic signed [NW-1:0]         num_mag;
    logic [2*RW-1:0]              recip_prod;
    logic signed [NW:0]           offset;
    logic signed [NW:0]           sum;
    logic signed [PW-1:0]         sat_val;
    logic [7:0]                   d8;
    logic [7:0]                   d8_mag;
    logic [7:0]                   idle_inc;
    logic [15:0]                  sc_inc;
    logic [15:0]                  reflow_m10;
    logic [9:0]                   ramp_step;
    logic signed [NW-1:0]         cnt_ext;
    logic signed [NW-1:0]         now_ext;
    logic signed [NW-1:0]         pre_ext;

    assign accept      = item.valid && item.ready;
    assign item.ready  = (state_reg == S_IDLE);
    assign out_free    = !out_valid_reg || result.ready;

    assign result.valid         = out_valid_reg;
    assign result.phase         = out_phase_reg;
    assign result.target_temp   = out_target_reg;
    assign result.progress      = out_progress_reg;
    assign result.sleep_request = out_sleep_reg;
    assign result.profile_done  = out_done_reg;

    // shared divider datapath
    assign div_shift  = {div_rem_reg, div_quo_reg[QW-1]};
    assign div_ge     = (div_shift >= {1'b0, div_den_reg});
    assign div_diff   = div_shift - {1'b0, div_den_reg};
    assign div_last   = (div_cnt_reg == rps_pkg::DCNT_W'(rps_pkg::DIV_STEPS - 1));
    assign quo_signed = div_neg_reg ? -$signed({1'b0, div_quo_reg})
                                    :  $signed({1'b0, div_quo_reg});

    assign cnt_ext = {{(NW-16){second_count_reg[15]}}, second_count_reg};
    assign now_ext = $signed(NW'(now_reg));
    assign pre_ext = $signed(NW'(preheat_reg));

    // per-phase numerators: divisor source, progress numerator, offset
    always_comb
    begin
        num1   = '0;
        num2   = '0;
        offset = '0;
        unique case (phase_reg)
            rps_pkg::PH_RAMP:
            begin
                num1   = mul10(pre_ext - NW'(39));
                num2   = mul10(now_ext - NW'(38));
                offset = '0;
            end
            rps_pkg::PH_SOAK:
            begin
                num1   = mul10($signed(NW'(soak_reg)));
                num2   = mul10(cnt_ext);
                offset = (NW+1)'(25);
            end
            rps_pkg::PH_HEAT:
            begin
                num1   = mul10(NW'(217) - pre_ext);
                num2   = mul10(now_ext - pre_ext);
                offset = (NW+1)'(50);
            end
            rps_pkg::PH_REFLOW:
            begin
                num1   = mul10($signed(NW'(reflow_reg)));
                num2   = mul10(cnt_ext);
                offset = (NW+1)'(75);
            end
            default:
            begin
                num1   = '0;
                num2   = '0;
                offset = '0;
            end
        endcase
    end

    assign num_sel = (state_reg == S_LOAD1) ? num1 : num2;
    assign num_mag = num_sel[NW-1] ? -num_sel : num_sel;

    // phase divisor numerators stay below 5120 in magnitude
    assign recip_prod = {{RW{1'b0}}, num_mag[RW-1:0]} * {{RW{1'b0}}, rps_pkg::RECIP25};

    always_comb
    begin
        d8 = quo_signed[7:0];
        if (d8 == 8'd0)
        begin
            d8 = 8'd1;
        end
        d8_mag = d8[7] ? (8'd0 - d8) : d8;
    end

    assign sum = {quo_signed[NW-1], quo_signed} + offset;

    always_comb
    begin
        if (sum > (NW+1)'(4095))
        begin
            sat_val = PW'(4095);
        end
        else if (sum < -(NW+1)'(4096))
        begin
            sat_val = -PW'(4096);
        end
        else
        begin
            sat_val = sum[PW-1:0];
        end
    end

    assign idle_inc   = idle_count_reg + 8'd1;
    assign sc_inc     = second_count_reg + 16'd1;
    assign reflow_m10 = 16'(reflow_reg) - 16'd10;
    assign ramp_step  = {2'b0, ramp_reg} + 10'd3;

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        second_count_next = second_count_reg;
        ramp_next         = ramp_reg;
        progress_next     = progress_reg;
        idle_count_next   = idle_count_reg;
        now_next          = now_reg;
        sleep_pend_next   = sleep_pend_reg;
        active_next       = active_reg;
        div_rem_next      = div_rem_reg;
        div_quo_next      = div_quo_reg;
        div_den_next      = div_den_reg;
        div_neg_next      = div_neg_reg;
        div_cnt_next      = div_cnt_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_phase_next    = out_phase_reg;
        out_target_next   = out_target_reg;
        out_progress_next = out_progress_reg;
        out_sleep_next    = out_sleep_reg;
        out_done_next     = out_done_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next = item.measured_temp;
                    if (item.op == rps_pkg::OP_START)
                    begin
                        phase_next      = rps_pkg::PH_RAMP;
                        ramp_next       = item.start_target;
                        sleep_pend_next = 1'b0;
                        active_next     = 1'b0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        if (item.measured_temp == TW'(38) && !item.heater_on)
                        begin
                            idle_count_next = idle_inc;
                            sleep_pend_next = (idle_inc == sleep_delay_reg) &&
                                              !item.display_asleep;
                        end
                        else
                        begin
                            idle_count_next = 8'd0;
                            sleep_pend_next = 1'b0;
                        end
                        if (item.temp_reached && sc_inc == 16'd60)
                        begin
                            second_count_next = 16'd0;
                        end
                        else
                        begin
                            second_count_next = sc_inc;
                        end
                        active_next = (phase_reg == rps_pkg::PH_RAMP) ||
                                      (phase_reg == rps_pkg::PH_SOAK) ||
                                      (phase_reg == rps_pkg::PH_HEAT) ||
                                      (phase_reg == rps_pkg::PH_REFLOW);
                        state_next  = active_next ? S_LOAD1 : S_FIN;
                    end
                end
            end
            S_LOAD1:
            begin
                div_quo_next = QW'(recip_prod[2*RW-1:rps_pkg::RECIP_SHIFT]);
                div_neg_next = num_sel[NW-1];
                state_next   = S_LOAD2;
            end
            S_DIV2:
            begin
                div_quo_next = {div_quo_reg[QW-2:0], div_ge};
                div_rem_next = div_ge ? div_diff[7:0] : div_shift[7:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_LOAD2:
            begin
                div_quo_next = num_mag[QW-1:0];
                div_rem_next = 8'd0;
                div_den_next = d8_mag;
                div_neg_next = num_sel[NW-1] ^ d8[7];
                div_cnt_next = '0;
                state_next   = S_DIV2;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_done_next = 1'b0;
                    if (active_reg)
                    begin
                        progress_next = sat_val;
                        unique case (phase_reg)
                            rps_pkg::PH_RAMP:
                            begin
                                if (({2'b0, ramp_reg} + 10'd1) < {2'b0, preheat_reg})
                                begin
                                    ramp_next = (ramp_step > {2'b0, preheat_reg}) ?
                                                preheat_reg : ramp_step[7:0];
                                end
                                else if (now_reg >= TW'(ramp_reg))
                                begin
                                    phase_next        = rps_pkg::PH_SOAK;
                                    second_count_next = 16'd0;
                                end
                            end
                            rps_pkg::PH_SOAK:
                            begin
                                if (second_count_reg == 16'(soak_reg))
                                begin
                                    phase_next = rps_pkg::PH_HEAT;
                                    ramp_next  = peak_reg;
                                end
                            end
                            rps_pkg::PH_HEAT:
                            begin
                                if (now_reg > TW'(215))
                                begin
                                    phase_next        = rps_pkg::PH_REFLOW;
                                    second_count_next = 16'd0;
                                end
                            end
                            rps_pkg::PH_REFLOW:
                            begin
                                if (second_count_reg == reflow_m10)
                                begin
                                    ramp_next = 8'd0;
                                end
                                else if (second_count_reg == 16'(reflow_reg))
                                begin
                                    phase_next    = rps_pkg::PH_IDLE;
                                    progress_next = PW'(100);
                                    out_done_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                progress_next = progress_reg;
                            end
                        endcase
                    end
                    out_valid_next    = 1'b1;
                    out_phase_next    = phase_next;
                    out_target_next   = ramp_next;
                    out_progress_next = progress_next;
                    out_sleep_next    = sleep_pend_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preheat_reg     <= 8'd150;
            soak_reg        <= 9'd90;
            peak_reg        <= 8'd230;
            reflow_reg      <= 9'd60;
            sleep_delay_reg <= 8'd60;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rps_pkg::CFG_PREHEAT:     preheat_reg     <= cfg_data[7:0];
                rps_pkg::CFG_SOAK:        soak_reg        <= cfg_data[8:0];
                rps_pkg::CFG_PEAK:        peak_reg        <= cfg_data[7:0];
                rps_pkg::CFG_REFLOW:      reflow_reg      <= cfg_data[8:0];
                rps_pkg::CFG_SLEEP_DELAY: sleep_delay_reg <= cfg_data[7:0];
                default:
                begin
                    preheat_reg <= preheat_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= rps_pkg::PH_IDLE;
            second_count_reg <= 16'd0;
            ramp_reg         <= 8'd0;
            progress_reg     <= '0;
            idle_count_reg   <= 8'd0;
            sleep_pend_reg   <= 1'b0;
            active_reg       <= 1'b0;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            second_count_reg <= second_count_next;
            ramp_reg         <= ramp_next;
            progress_reg     <= progress_next;
            idle_count_reg   <= idle_count_next;
            sleep_pend_reg   <= sleep_pend_next;
            active_reg       <= active_next;
            div_cnt_reg      <= div_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg          <= now_next;
        div_rem_reg      <= div_rem_next;
        div_quo_reg      <= div_quo_next;
        div_den_reg      <= div_den_next;
        div_neg_reg      <= div_neg_next;
        out_phase_reg    <= out_phase_next;
        out_target_reg   <= out_target_next;
        out_progress_reg <= out_progress_next;
        out_sleep_reg    <= out_sleep_next;
        out_done_reg     <= out_done_next;
    end

endmodule

### tb/reflow_profile_checker.sv
`timescale 1ns / 1ps

module reflow_profile_checker
    import rps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rps_in_if                    item,
    rps_out_if                   result,
    output int                   errors,
    output int                   pending,
    output int                   result_count,
    output int                   done_count,
    output int                   sleep_count
);

    localparam int AMBIENT_TEMP = 38;
    localparam int RAMP_BASE    = 39;
    localparam int PEAK_LIMIT   = 217;
    localparam int REFLOW_TEMP  = 215;
    localparam int COUNT_CLEAR  = 60;
    localparam int RAMP_STEP    = 3;
    localparam int ZERO_LEAD    = 10;
    localparam int PROG_MAX     = 4095;
    localparam int PROG_MIN     = -4096;
    localparam int PROG_DONE    = 100;

    typedef struct {
        logic [PHASE_W-1:0]       phase;
        logic [7:0]               target_temp;
        logic signed [PROG_W-1:0] progress;
        logic                     sleep_request;
        logic                     profile_done;
    } status_t;

    logic [7:0]               preheat_r;
    logic [8:0]               soak_r;
    logic [7:0]               peak_r;
    logic [8:0]               reflow_r;
    logic [7:0]               sleep_r;

    logic [PHASE_W-1:0]       phase_q;
    logic [15:0]              count_q;
    logic [7:0]               ramp_q;
    logic signed [PROG_W-1:0] prog_q;
    logic [7:0]               idle_q;

    status_t status_q[$];

    function automatic int phase_divisor(input int q);
        logic signed [7:0] b;
        b = q[7:0];
        return (b == 0) ? 1 : int'(b);
    endfunction

    function automatic logic signed [PROG_W-1:0] clamp_progress(input int v);
        if (v > PROG_MAX)
            return PROG_MAX[PROG_W-1:0];
        if (v < PROG_MIN)
            return PROG_MIN[PROG_W-1:0];
        return v[PROG_W-1:0];
    endfunction

    function automatic status_t step_sequencer(input logic op_v, input logic [8:0] temp_v,
                                               input logic heat_v, input logic reach_v,
                                               input logic asleep_v, input logic [7:0] start_v);
        status_t s;
        int      now;
        int      pre;
        int      d;
        int      cnt;
        int      t;
        s.sleep_request = 1'b0;
        s.profile_done  = 1'b0;
        if (op_v == OP_START)
        begin
            phase_q = PH_RAMP;
            ramp_q  = start_v;
        end
        else
        begin
            now = int'(temp_v);
            pre = int'(preheat_r);
            if (now == AMBIENT_TEMP && !heat_v)
            begin
                idle_q = idle_q + 8'd1;
                if (idle_q == sleep_r && !asleep_v)
                    s.sleep_request = 1'b1;
            end
            else
                idle_q = 8'd0;

            count_q = count_q + 16'd1;
            if (reach_v && count_q == COUNT_CLEAR[15:0])
                count_q = 16'd0;
            cnt = int'($signed(count_q));

            case (phase_q)
                PH_RAMP:
                begin
                    d = phase_divisor((pre - RAMP_BASE) * 10 / 25);
                    prog_q = clamp_progress((now - AMBIENT_TEMP) * 10 / d);
                    if (int'(ramp_q) < pre - 1)
                    begin
                        t = int'(ramp_q) + RAMP_STEP;
                        ramp_q = (t > pre) ? preheat_r : t[7:0];
                    end
                    else if (now >= int'(ramp_q))
                    begin
                        phase_q = PH_SOAK;
                        count_q = 16'd0;
                    end
                end
                PH_SOAK:
                begin
                    d = phase_divisor(int'(soak_r) * 10 / 25);
                    prog_q = clamp_progress(25 + cnt * 10 / d);
                    if (cnt == int'(soak_r))
                    begin
                        phase_q = PH_HEAT;
                        ramp_q  = peak_r;
                    end
                end
                PH_HEAT:
                begin
                    d = phase_divisor((PEAK_LIMIT - pre) * 10 / 25);
                    prog_q = clamp_progress(50 + (now - pre) * 10 / d);
                    if (now > REFLOW_TEMP)
                    begin
                        phase_q = PH_REFLOW;
                        count_q = 16'd0;
                    end
                end
                PH_REFLOW:
                begin
                    d = phase_divisor(int'(reflow_r) * 10 / 25);
                    prog_q = clamp_progress(75 + cnt * 10 / d);
                    if (cnt == int'(reflow_r) - ZERO_LEAD)
                        ramp_q = 8'd0;
                    else if (cnt == int'(reflow_r))
                    begin
                        phase_q = PH_IDLE;
                        prog_q  = PROG_DONE[PROG_W-1:0];
                        s.profile_done = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        s.phase       = phase_q;
        s.target_temp = ramp_q;
        s.progress    = prog_q;
        return s;
    endfunction

    task automatic report_field(input string field, input int exp_v, input int act_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_t exp_s;
        if (!rst_n)
        begin
            preheat_r    = 8'd150;
            soak_r       = 9'd90;
            peak_r       = 8'd230;
            reflow_r     = 9'd60;
            sleep_r      = 8'd60;
            phase_q      = PH_IDLE;
            count_q      = 16'd0;
            ramp_q       = 8'd0;
            prog_q       = '0;
            idle_q       = 8'd0;
            errors       = 0;
            result_count = 0;
            done_count   = 0;
            sleep_count  = 0;
            status_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PREHEAT:     preheat_r = cfg_data[7:0];
                    CFG_SOAK:        soak_r    = cfg_data[8:0];
                    CFG_PEAK:        peak_r    = cfg_data[7:0];
                    CFG_REFLOW:      reflow_r  = cfg_data[8:0];
                    CFG_SLEEP_DELAY: sleep_r   = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            if (result.valid && result.ready)
            begin
                result_count++;
                if (result.profile_done === 1'b1)
                    done_count++;
                if (result.sleep_request === 1'b1)
                    sleep_count++;
                if (status_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with no item outstanding, phase %0d",
                             $time, result.phase);
                end
                else
                begin
                    exp_s = status_q.pop_front();
                    if (result.phase !== exp_s.phase)
                        report_field("phase", int'(exp_s.phase), int'(result.phase));
                    if (result.target_temp !== exp_s.target_temp)
                        report_field("target_temp", int'(exp_s.target_temp),
                                     int'(result.target_temp));
                    if (result.progress !== exp_s.progress)
                        report_field("progress", int'(exp_s.progress), int'(result.progress));
                    if (result.sleep_request !== exp_s.sleep_request)
                        report_field("sleep_request", int'(exp_s.sleep_request),
                                     int'(result.sleep_request));
                    if (result.profile_done !== exp_s.profile_done)
                        report_field("profile_done", int'(exp_s.profile_done),
                                     int'(result.profile_done));
                end
            end

            if (item.valid && item.ready)
                status_q.push_back(step_sequencer(item.op, item.measured_temp, item.heater_on,
                                                  item.temp_reached, item.display_asleep,
                                                  item.start_target));

            pending <= status_q.size();
        end
    end

endmodule

### tb/reflow_profile_sequencer_test.sv
`timescale 1ns / 1ps

module reflow_profile_sequencer_test;

    import rps_pkg::*;

    localparam int PLAN_ITEMS    = 1100;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 60;
    localparam int IDLE_LIMIT    = 4000;
    localparam int AMBIENT_TEMP  = 38;
    localparam int LONG_IDLE     = 260;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rps_in_if  item_bus ();
    rps_out_if result_bus ();

    int errors;
    int pending;
    int result_count;
    int done_count;
    int sleep_count;

    int send_gap_pct = 16;
    int recv_gap_pct = 88;
    bit hold_req     = 1'b0;
    int items_sent   = 0;
    int starts_sent  = 0;
    int settings     = 0;
    int quiet_cycles = 0;

    reflow_profile_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .result    (result_bus)
    );

    reflow_profile_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item_bus),
        .result       (result_bus),
        .errors       (errors),
        .pending      (pending),
        .result_count (result_count),
        .done_count   (done_count),
        .sleep_count  (sleep_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls, plus one long hold once the no-idle stretch begins
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= (int'($urandom_range(99)) >= recv_gap_pct);
        end
    end

    task automatic send_item(input logic op_v, input logic [TEMP_WIDTH-1:0] temp_v,
                             input logic heat_v, input logic reach_v, input logic asleep_v,
                             input logic [7:0] start_v);
        if (items_sent >= 2 * PLAN_ITEMS / 3)
        begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
            hold_req     = 1'b1;
        end
        else if (items_sent >= PLAN_ITEMS / 3)
        begin
            send_gap_pct = 88;
            recv_gap_pct = 16;
        end
        while (int'($urandom_range(99)) < send_gap_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid          <= 1'b1;
        item_bus.op             <= op_v;
        item_bus.measured_temp  <= temp_v;
        item_bus.heater_on      <= heat_v;
        item_bus.temp_reached   <= reach_v;
        item_bus.display_asleep <= asleep_v;
        item_bus.start_target   <= start_v;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_tick(input int temp_v, input logic heat_v, input logic reach_v,
                             input logic asleep_v);
        send_item(OP_TICK, temp_v[TEMP_WIDTH-1:0], heat_v, reach_v, asleep_v,
                  8'($urandom_range(255)));
    endtask

    task automatic send_start(input int target_v);
        starts_sent++;
        send_item(OP_START, TEMP_WIDTH'($urandom_range(511)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), target_v[7:0]);
    endtask

    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    // bit 8 on an 8-bit register must be dropped
    function automatic int spare_bit();
        return ($urandom_range(3) == 0) ? 256 : 0;
    endfunction

    task automatic write_profile(input int pre, input int soak, input int peak, input int refl,
                                 input int slp);
        write_reg(CFG_PREHEAT, pre | spare_bit());
        write_reg(CFG_SOAK, soak);
        write_reg(CFG_PEAK, peak | spare_bit());
        write_reg(CFG_REFLOW, refl);
        write_reg(CFG_SLEEP_DELAY, slp | spare_bit());
        write_reg(CFG_IDX_W'(int'(CFG_SLEEP_DELAY) + 1 + int'($urandom_range(2))),
                  int'($urandom_range(511)));
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        int seq;
        int n;
        int hot;
        int temp;
        int pre;
        int soak;
        int peak;
        int refl;
        int slp;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        item_bus.valid          = 1'b0;
        item_bus.op             = OP_TICK;
        item_bus.measured_temp  = '0;
        item_bus.heater_on      = 1'b0;
        item_bus.temp_reached   = 1'b0;
        item_bus.display_asleep = 1'b0;
        item_bus.start_target   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: sleep request, saturated ramp progress, one-tick soak, full reflow hold
        write_profile(40, 1, 255, 11, 1);
        send_tick(AMBIENT_TEMP, 1'b0, 1'b0, 1'b0);
        send_tick(AMBIENT_TEMP, 1'b0, 1'b0, 1'b1);
        send_tick(AMBIENT_TEMP - 1, 1'b0, 1'b1, 1'b0);
        send_start(255);
        send_tick(511, 1'b1, 1'b0, 1'b0);
        send_tick(0, 1'b1, 1'b0, 1'b0);
        send_tick(215, 1'b1, 1'b1, 1'b0);
        send_tick(216, 1'b1, 1'b0, 1'b0);
        for (int i = 0; i < 11; i++)
            send_tick(220 + i, i[0], 1'b0, 1'b0);
        send_tick(AMBIENT_TEMP, 1'b1, 1'b0, 1'b0);

        // directed: ramp step clamped at preheat, wait for plate before soak
        wait_idle();
        write_profile(100, 2, 0, 12, 0);
        send_start(95);
        send_tick(60, 1'b1, 1'b0, 1'b0);
        send_tick(80, 1'b1, 1'b0, 1'b0);
        send_tick(90, 1'b1, 1'b0, 1'b0);
        send_tick(150, 1'b1, 1'b0, 1'b0);

        seq = 0;
        while (items_sent < PLAN_ITEMS)
        begin
            wait_idle();
            if (seq == 0)
            begin
                pre = 0; soak = 0; peak = 0; refl = 0; slp = 0;
            end
            else if (seq == 1)
            begin
                pre = 255; soak = 511; peak = 255; refl = 511; slp = 255;
            end
            else
            begin
                pre  = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(200, 60);
                soak = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(15, 1);
                peak = $urandom_range(255);
                refl = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(25, 11);
                slp  = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(12, 1);
            end
            write_profile(pre, soak, peak, refl, slp);

            // idle counter wraps through zero
            if (seq == 0)
                repeat (LONG_IDLE)
                    send_tick(AMBIENT_TEMP, 1'b0, $urandom_range(9) == 0, 1'b0);

            if (seq > 1 && $urandom_range(9) == 0)
            begin
                n = $urandom_range(60, 20);
                repeat (n)
                begin
                    if ($urandom_range(7) == 0)
                        send_start($urandom_range(255));
                    else
                        send_tick($urandom_range(511), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
            else
            begin
                send_start($urandom_range(255));
                temp = $urandom_range(60, 20);
                n    = $urandom_range(140, 50);
                hot  = $urandom_range(n, n / 2);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(49) == 0)
                        send_start($urandom_range(255));
                    else if ($urandom_range(19) == 0)
                        send_tick($urandom_range(511), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                    else if (i < hot)
                    begin
                        temp = temp + $urandom_range(7);
                        if (temp > 290)
                            temp = 290 - $urandom_range(20);
                        send_tick(temp, $urandom_range(3) != 0, $urandom_range(9) == 0,
                                  $urandom_range(3) == 0);
                    end
                    else if ($urandom_range(4) != 0)
                        send_tick(AMBIENT_TEMP, 1'b0, $urandom_range(9) == 0,
                                  $urandom_range(3) == 0);
                    else
                        send_tick($urandom_range(100), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
            seq++;
        end

        wait_idle();
        $display("Covered %0d items (%0d starts) over %0d register settings, %0d results checked",
                 items_sent, starts_sent, settings, result_count);
        $display("Profiles completed: %0d, sleep requests: %0d, one long output hold",
                 done_count, sleep_count);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
design/rps_pkg.sv
design/rps_if.sv
design/reflow_profile_sequencer.sv
tb/reflow_profile_checker.sv
tb/reflow_profile_sequencer_test.sv
